// ===== hdl/srwm_pkg.sv =====
`default_nettype none
package srwm_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AvgW    = 13;
  localparam int unsigned GainW   = 16;
  localparam int unsigned OffW    = 13;
  localparam int unsigned MvW     = 16;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // fixed ratio 1.221 held as 20005 / 2^14
  localparam int unsigned RatioNum = 20005;
  localparam int unsigned RatioW   = 15;
  localparam int unsigned ScaleShift = 28;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCalGain    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCalOffset  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWindowHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFaultLimit = 3'd4;

  localparam logic [GainW-1:0]  CalGainRst    = 16'd16384;
  localparam logic [OffW-1:0]   CalOffsetRst  = 13'd0;
  localparam logic [MvW-1:0]    WindowLowRst  = 16'd4750;
  localparam logic [MvW-1:0]    WindowHighRst = 16'd5250;
  localparam logic [LimitW-1:0] FaultLimitRst = 8'd50;

  typedef struct packed {
    logic            valid;
    logic [AvgW-1:0] avg;
  } avg_xfer_t;

  typedef struct packed {
    logic [GainW-1:0]  cal_gain;
    logic [OffW-1:0]   cal_offset;
    logic [MvW-1:0]    window_low;
    logic [MvW-1:0]    window_high;
    logic [LimitW-1:0] fault_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/supply_rail_window_monitor.sv =====
`default_nettype none
// Supply rail window monitor. Raw 12-bit ADC samples enter one transaction per
// clock while in_stall_o is low. Samples form groups of GROUP_SAMPLES; the
// first of each group is dropped, the rest are summed, and on the last sample
// the sum is shifted right by AVG_SHIFT and doubled (capped at 8191). That
// average is scaled by 1.221 (20005/2^14) and the Q2.14 cal_gain, offset by
// cal_offset mV and saturated to 0..65535 mV. Each group out of [window_low,
// window_high] extends a bad run; a run beyond fault_limit pins the count at
// fault_limit + 1 and raises rail_fault. One result transaction is produced
// per group, none otherwise. Rate: the sample side takes one sample per cycle
// while in_stall_o is low. The scaling back end is a five-step sequencer
// (queue pop, two multiplies, saturate, then window check with output load),
// and a stalled result channel holds it in the window check; a 2-entry queue
// sits between the accumulator and the back end and in_stall_o rises only
// when it is full. With the queue empty and the result channel free, a group
// average moves via avg_q, p1_q, p2_q and mv_q to the outputs, raising out_valid_o.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// must only be issued while the block is idle.
module supply_rail_window_monitor #(
  parameter int unsigned GROUP_SAMPLES = 9,
  parameter int unsigned AVG_SHIFT     = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [srwm_pkg::SampleW-1:0]      adc_sample_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [srwm_pkg::AvgW-1:0]              averaged_raw_o,
  output logic [srwm_pkg::MvW-1:0]               rail_millivolts_o,
  output logic                                   rail_fault_o,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [srwm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [srwm_pkg::CfgDataW-1:0]     cfg_data_i
);

  srwm_pkg::cfg_t      cfg_q;
  srwm_pkg::avg_xfer_t push, head;
  logic                q_full, pop, in_accept, cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // register file; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_gain    <= srwm_pkg::CalGainRst;
      cfg_q.cal_offset  <= srwm_pkg::CalOffsetRst;
      cfg_q.window_low  <= srwm_pkg::WindowLowRst;
      cfg_q.window_high <= srwm_pkg::WindowHighRst;
      cfg_q.fault_limit <= srwm_pkg::FaultLimitRst;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        srwm_pkg::RegCalGain:    cfg_q.cal_gain    <= cfg_data_i;
        srwm_pkg::RegCalOffset:  cfg_q.cal_offset  <= cfg_data_i[srwm_pkg::OffW-1:0];
        srwm_pkg::RegWindowLow:  cfg_q.window_low  <= cfg_data_i;
        srwm_pkg::RegWindowHigh: cfg_q.window_high <= cfg_data_i;
        srwm_pkg::RegFaultLimit: cfg_q.fault_limit <= cfg_data_i[srwm_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // stall only when the queue cannot take another group average
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  srwm_front #(
    .GROUP_SAMPLES(GROUP_SAMPLES),
    .AVG_SHIFT    (AVG_SHIFT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .adc_sample_i(adc_sample_i),
    .push_o      (push)
  );

  srwm_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .full_o(q_full)
  );

  srwm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .averaged_raw_o   (averaged_raw_o),
    .rail_millivolts_o(rail_millivolts_o),
    .rail_fault_o     (rail_fault_o)
  );

endmodule
`default_nettype wire

// ===== hdl/srwm_front.sv =====
`default_nettype none
module srwm_front #(
  parameter int unsigned GROUP_SAMPLES = 9,
  parameter int unsigned AVG_SHIFT     = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [srwm_pkg::SampleW-1:0]    adc_sample_i,
  output srwm_pkg::avg_xfer_t                  push_o
);

  localparam int unsigned SumMax = (GROUP_SAMPLES - 1) * 4095;
  localparam int unsigned SumW   = $clog2(SumMax + 1);
  localparam int unsigned IdxW   = $clog2(GROUP_SAMPLES);
  localparam int unsigned DblW   = SumW + 1;
  localparam int unsigned AvgMax = (1 << srwm_pkg::AvgW) - 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(GROUP_SAMPLES - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] sum_add;
  logic [DblW-1:0] dbl;
  logic            last;

  // first sample of a group is dropped
  assign sum_add = (idx_q != '0) ? sum_q + SumW'(adc_sample_i) : sum_q;
  assign last    = (idx_q == LastIdx);
  assign dbl     = {sum_add >> AVG_SHIFT, 1'b0};

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    push_o.valid = 1'b0;
    push_o.avg   = (dbl > DblW'(AvgMax)) ? srwm_pkg::AvgW'(AvgMax)
                                         : dbl[srwm_pkg::AvgW-1:0];
    if (accept_i) begin
      if (last) begin
        idx_d = '0;
        sum_d = '0;
        push_o.valid = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
        sum_d = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srwm_queue.sv =====
`default_nettype none
module srwm_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire srwm_pkg::avg_xfer_t  push_i,
  input  wire logic                 pop_i,
  output srwm_pkg::avg_xfer_t       head_o,
  output logic                      full_o
);

  logic [srwm_pkg::AvgW-1:0] mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign do_pop       = pop_i && (cnt_q != 2'd0);
  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.avg   = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_ptr_q] <= push_i.avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i.valid && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i.valid && do_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srwm_back.sv =====
`default_nettype none
module srwm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srwm_pkg::cfg_t                cfg_i,
  input  wire srwm_pkg::avg_xfer_t           head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [srwm_pkg::AvgW-1:0]          averaged_raw_o,
  output logic [srwm_pkg::MvW-1:0]           rail_millivolts_o,
  output logic                               rail_fault_o
);

  localparam int unsigned P1W  = srwm_pkg::AvgW + srwm_pkg::RatioW;
  localparam int unsigned P2W  = P1W + srwm_pkg::GainW;
  localparam int unsigned TotW = P2W + 2;
  localparam int unsigned QW   = TotW - srwm_pkg::ScaleShift;
  localparam int unsigned PadW = TotW - srwm_pkg::OffW - srwm_pkg::ScaleShift;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StSat  = 3'd3;
  localparam logic [2:0] StWin  = 3'd4;

  logic [2:0] state_q;
  logic [srwm_pkg::AvgW-1:0] avg_q;
  logic [P1W-1:0] p1_q;
  logic [P2W-1:0] p2_q;
  logic [srwm_pkg::MvW-1:0] mv_q;
  logic [srwm_pkg::LimitW-1:0] cnt_q;
  logic out_valid_q;

  logic signed [TotW-1:0] off_sc, total;
  logic [QW-1:0] q;
  logic [srwm_pkg::MvW-1:0] mv_d;
  logic out_free, bad;
  logic [srwm_pkg::LimitW:0] cnt_inc, lim_ext;
  logic [srwm_pkg::LimitW-1:0] cnt_d;
  logic fault_d;

  assign pop_o    = (state_q == StIdle) && head_i.valid;
  assign out_free = !out_valid_q || !out_stall_i;

  // offset scaled to 2^28 and added to the exact product
  assign off_sc = $signed({{PadW{cfg_i.cal_offset[srwm_pkg::OffW-1]}}, cfg_i.cal_offset,
                           {srwm_pkg::ScaleShift{1'b0}}});
  assign total  = $signed({2'b00, p2_q}) + off_sc;
  assign q      = total[TotW-1:srwm_pkg::ScaleShift];

  always_comb begin
    if (total[TotW-1] || (total == '0)) begin
      mv_d = '0;
    end else if (q > QW'({srwm_pkg::MvW{1'b1}})) begin
      mv_d = '1;
    end else begin
      mv_d = q[srwm_pkg::MvW-1:0];
    end
  end

  // bad-run counter: saturates at all ones, pins at limit + 1
  assign bad     = (mv_q < cfg_i.window_low) || (mv_q > cfg_i.window_high);
  assign lim_ext = {1'b0, cfg_i.fault_limit};
  always_comb begin
    if (!bad) begin
      cnt_inc = '0;
    end else if (cnt_q != '1) begin
      cnt_inc = {1'b0, cnt_q} + 1'b1;
    end else begin
      cnt_inc = {1'b0, cnt_q};
    end
    if (cnt_inc > lim_ext) begin
      cnt_d   = cfg_i.fault_limit + 1'b1;
      fault_d = 1'b1;
    end else begin
      cnt_d   = cnt_inc[srwm_pkg::LimitW-1:0];
      fault_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      avg_q <= head_i.avg;
    end
    if (state_q == StMul1) begin
      p1_q <= P1W'(avg_q) * P1W'(srwm_pkg::RatioNum);
    end
    if (state_q == StMul2) begin
      p2_q <= P2W'(p1_q) * P2W'(cfg_i.cal_gain);
    end
    if (state_q == StSat) begin
      mv_q <= mv_d;
    end
    if ((state_q == StWin) && out_free) begin
      averaged_raw_o    <= avg_q;
      rail_millivolts_o <= mv_q;
      rail_fault_o      <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (head_i.valid) state_q <= StMul1;
        StMul1: state_q <= StMul2;
        StMul2: state_q <= StSat;
        StSat:  state_q <= StWin;
        StWin: begin
          if (out_free) begin
            cnt_q   <= cnt_d;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      // a new load takes the register even when the old result leaves now
      if ((state_q == StWin) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
